// File: rtl/rrcm_pkg.sv
// ----------------------------------------------------------------------------
// rrcm_pkg
// Shared constants and types for the round-robin crossbar matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package rrcm_pkg;

	// Field layout is fixed at eight ports; NUM_PORTS may be 2..8
	localparam int MAX_PORTS = 8;
	localparam int IDX_W     = 3;
	localparam int REQ_W     = MAX_PORTS * MAX_PORTS;
	localparam int GNT_IDX_W = MAX_PORTS * IDX_W;

	// Active ports; requests and grants beyond this are ignored / zero
	localparam int NUM_PORTS = 8;

	// Scan position: holds up to 2*NUM_PORTS-1
	localparam int POS_W = IDX_W + 2;

	// Round-robin pointer or a grant: valid bit plus input index
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} ptr_t;

endpackage

`default_nettype wire

// File: rtl/rrcm_arb.sv
// ----------------------------------------------------------------------------
// rrcm_arb
// Round-robin grant for one output: first requesting, still unmatched input,
// scanning from one past the last granted input (or from input 0).
// ----------------------------------------------------------------------------
`default_nettype none

module rrcm_arb (
	input  wire logic [rrcm_pkg::MAX_PORTS-1:0] req,
	input  wire logic [rrcm_pkg::MAX_PORTS-1:0] taken,
	input  wire rrcm_pkg::ptr_t                 ptr,
	output rrcm_pkg::ptr_t                      grant
);

	logic [rrcm_pkg::POS_W-1:0] start;
	logic [rrcm_pkg::POS_W-1:0] pos;
	logic                       found;

	// Scan start: one past the pointer, or input 0 when the pointer is empty
	always_comb begin
		if (ptr.vld) begin
			start = rrcm_pkg::POS_W'(ptr.idx) + rrcm_pkg::POS_W'(1);
		end else begin
			start = '0;
		end
	end

	// Wrap-around priority scan over the active inputs
	always_comb begin
		found = 1'b0;
		grant = '0;
		pos   = '0;
		for (int k = 0; k < rrcm_pkg::NUM_PORTS; k++) begin
			pos = start + rrcm_pkg::POS_W'(k);
			if (pos >= rrcm_pkg::POS_W'(rrcm_pkg::NUM_PORTS)) begin
				pos = pos - rrcm_pkg::POS_W'(rrcm_pkg::NUM_PORTS);
			end
			if (!found && req[pos[rrcm_pkg::IDX_W-1:0]] && !taken[pos[rrcm_pkg::IDX_W-1:0]]) begin
				found     = 1'b1;
				grant.vld = 1'b1;
				grant.idx = pos[rrcm_pkg::IDX_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/rrcm_core.sv
// ----------------------------------------------------------------------------
// rrcm_core
// Grant chain over all outputs plus the per-output round-robin pointers.
// Pointers advance only when the current slot moves to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrcm_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic [rrcm_pkg::REQ_W-1:0]     req,
	output logic      [rrcm_pkg::MAX_PORTS-1:0] gnt_vld,
	output logic      [rrcm_pkg::GNT_IDX_W-1:0] gnt_idx
);

	rrcm_pkg::ptr_t [rrcm_pkg::NUM_PORTS-1:0]   ptr_q;
	rrcm_pkg::ptr_t [rrcm_pkg::NUM_PORTS-1:0]   grant;
	logic [rrcm_pkg::NUM_PORTS:0][rrcm_pkg::MAX_PORTS-1:0] taken;
	logic [rrcm_pkg::MAX_PORTS-1:0]             any_req;

	assign taken[0] = '0;

	// One arbiter per output, each masking inputs matched by earlier outputs
	for (genvar o = 0; o < rrcm_pkg::NUM_PORTS; o++) begin : g_out
		rrcm_arb u_arb (
			.req   (req[o*rrcm_pkg::MAX_PORTS +: rrcm_pkg::MAX_PORTS]),
			.taken (taken[o]),
			.ptr   (ptr_q[o]),
			.grant (grant[o])
		);

		assign taken[o+1] = grant[o].vld
			? (taken[o] | (rrcm_pkg::MAX_PORTS'(1) << grant[o].idx))
			: taken[o];
	end

	// Pack grants into result fields; unused outputs stay zero
	always_comb begin
		gnt_vld = '0;
		gnt_idx = '0;
		for (int o = 0; o < rrcm_pkg::NUM_PORTS; o++) begin
			gnt_vld[o]                                  = grant[o].vld;
			gnt_idx[o*rrcm_pkg::IDX_W +: rrcm_pkg::IDX_W] = grant[o].idx;
		end
	end

	// Pointer takes the grant, or goes empty with index 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (en) begin
			ptr_q <= grant;
		end
	end

	// Per-output "any active request" for the checks below
	always_comb begin
		any_req = '0;
		for (int o = 0; o < rrcm_pkg::NUM_PORTS; o++) begin
			any_req[o] = |req[o*rrcm_pkg::MAX_PORTS +: rrcm_pkg::NUM_PORTS];
		end
	end

	// Each grant claims exactly one distinct input
	a_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		en |-> ($countones(taken[rrcm_pkg::NUM_PORTS]) == $countones(gnt_vld)))
		else $error("rrcm_core: grants do not map to distinct inputs");

	// No grant for an output without requests
	a_grant_req: assert property (@(posedge clk) disable iff (!arst_n)
		en |-> ((gnt_vld & ~any_req) == '0))
		else $error("rrcm_core: grant without request");

	// Pointers hold while the slot is stalled
	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(ptr_q))
		else $error("rrcm_core: pointer moved without a slot");

endmodule

`default_nettype wire

// File: rtl/round_robin_crossbar_matcher.sv
// Path: a request matrix waits in the input register and its matching is
// registered in the result register. Throughput: one request matrix per cycle
// unless out_ready stalls the result register; the grant chain and the pointer
// update both finish within the stage between input and result registers.
// Reset: all round-robin pointers empty (scans start at input 0), both pipeline stages empty.
// ----------------------------------------------------------------------------
// round_robin_crossbar_matcher
// Single-iteration round-robin crossbar matcher: one matching per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_crossbar_matcher (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [rrcm_pkg::REQ_W-1:0]     request_matrix,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [rrcm_pkg::MAX_PORTS-1:0] grant_valid,
	output logic      [rrcm_pkg::GNT_IDX_W-1:0] grant_inputs
);

	logic                           valid_s1;
	logic [rrcm_pkg::REQ_W-1:0]     req_s1;
	logic                           adv;
	logic [rrcm_pkg::MAX_PORTS-1:0] gnt_vld;
	logic [rrcm_pkg::GNT_IDX_W-1:0] gnt_idx;

	// Stage moves when the result register is free or being drained
	assign adv      = !out_valid || out_ready;
	assign in_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= request_matrix;
		end
	end

	rrcm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (valid_s1 && adv),
		.req     (req_s1),
		.gnt_vld (gnt_vld),
		.gnt_idx (gnt_idx)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			grant_valid  <= gnt_vld;
			grant_inputs <= gnt_idx;
		end
	end

	// A stalled slot keeps its requests
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(req_s1)))
		else $error("matcher: stalled slot lost");

	// An empty input stage always takes a transaction
	a_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("matcher: empty stage not ready");

	// A slot that advances shows up as a result
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv) |=> out_valid)
		else $error("matcher: advanced slot missing on output");

endmodule

`default_nettype wire

// File: dv/round_robin_crossbar_matcher_tb.sv
// ----------------------------------------------------------------------------
// round_robin_crossbar_matcher_tb
// Self-checking bench for the single-iteration round-robin crossbar matcher.
// Request matrices go in over a valid/ready channel and matchings come out
// over another. A scoreboard keeps its own copy of the per-output round-robin
// pointers, predicts each matching, and compares it field by field. Both
// sides idle and stall at random, with bursts of back-to-back traffic.
// ----------------------------------------------------------------------------

module round_robin_crossbar_matcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// One matching as it appears on the result ports
	typedef struct packed {
		logic [rrcm_pkg::MAX_PORTS-1:0] vld;
		logic [rrcm_pkg::GNT_IDX_W-1:0] idx;
	} matching_t;

	// Predicts matchings from accepted request matrices and checks results
	class grant_scoreboard;
		rrcm_pkg::ptr_t last_grant[rrcm_pkg::MAX_PORTS];
		matching_t      matching_q[$];
		int             errors;
		int             requests;
		int             matchings;
		int             grants;
		int             idle_outputs;

		function new();
			for (int o = 0; o < rrcm_pkg::MAX_PORTS; o++) last_grant[o] = '0;
			errors       = 0;
			requests     = 0;
			matchings    = 0;
			grants       = 0;
			idle_outputs = 0;
		endfunction

		function int pending();
			return matching_q.size();
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t ns: %s", $time, what);
			errors++;
		endtask

		// Grant phase for one slot: outputs in order, each scanning round robin
		// from one past its last grant, skipping inputs already matched.
		function void note_request(logic [rrcm_pkg::REQ_W-1:0] req);
			logic [rrcm_pkg::MAX_PORTS-1:0] taken;
			matching_t                      m;
			int                             start;
			int                             in_idx;
			taken = '0;
			m     = '0;
			for (int o = 0; o < rrcm_pkg::NUM_PORTS; o++) begin
				start = last_grant[o].vld ? int'(last_grant[o].idx) + 1 : 0;
				last_grant[o] = '0;
				for (int k = 0; k < rrcm_pkg::NUM_PORTS; k++) begin
					in_idx = (start + k) % rrcm_pkg::NUM_PORTS;
					if (!m.vld[o] && req[o*rrcm_pkg::MAX_PORTS+in_idx] && !taken[in_idx]) begin
						taken[in_idx] = 1'b1;
						m.vld[o]      = 1'b1;
						m.idx[o*rrcm_pkg::IDX_W +: rrcm_pkg::IDX_W] =
							rrcm_pkg::IDX_W'(in_idx);
						last_grant[o].vld = 1'b1;
						last_grant[o].idx = rrcm_pkg::IDX_W'(in_idx);
					end
				end
			end
			matching_q = {matching_q, m};
			requests++;
		endfunction

		task check_grant(logic [rrcm_pkg::MAX_PORTS-1:0] gv,
				logic [rrcm_pkg::GNT_IDX_W-1:0] gi);
			matching_t m;
			if (matching_q.size() == 0) begin
				report_mismatch($sformatf("matching with none expected: valid=%h inputs=%h",
					gv, gi));
				return;
			end
			m = matching_q.pop_front();
			matchings++;
			if (gv !== m.vld)
				report_mismatch($sformatf("matching %0d grant_valid %h, expected %h",
					matchings, gv, m.vld));
			if (gi !== m.idx)
				report_mismatch($sformatf("matching %0d grant_inputs %h, expected %h",
					matchings, gi, m.idx));
			for (int o = 0; o < rrcm_pkg::NUM_PORTS; o++) begin
				if (m.vld[o]) grants++;
				else idle_outputs++;
			end
		endtask
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic [rrcm_pkg::REQ_W-1:0]     request_matrix;
	logic                           out_valid;
	logic                           out_ready;
	logic [rrcm_pkg::MAX_PORTS-1:0] grant_valid;
	logic [rrcm_pkg::GNT_IDX_W-1:0] grant_inputs;

	grant_scoreboard board;

	round_robin_crossbar_matcher u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.request_matrix (request_matrix),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.grant_valid    (grant_valid),
		.grant_inputs   (grant_inputs)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Random request matrix of varying density and contention
	function automatic logic [rrcm_pkg::REQ_W-1:0] random_matrix();
		logic [rrcm_pkg::REQ_W-1:0]     m;
		logic [rrcm_pkg::MAX_PORTS-1:0] hot;
		case ($urandom_range(0, 4))
			0: m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			1: m = {$urandom, $urandom} | {$urandom, $urandom};
			2: begin
				// few inputs wanted by many outputs
				hot = rrcm_pkg::MAX_PORTS'($urandom) & rrcm_pkg::MAX_PORTS'($urandom);
				for (int o = 0; o < rrcm_pkg::MAX_PORTS; o++)
					m[o*rrcm_pkg::MAX_PORTS +: rrcm_pkg::MAX_PORTS] =
						hot & rrcm_pkg::MAX_PORTS'($urandom | $urandom);
			end
			default: m = {$urandom, $urandom};
		endcase
		return m;
	endfunction

	// One transaction on the request side, after gap idle cycles
	task automatic send_matrix(input logic [rrcm_pkg::REQ_W-1:0] req, input int gap);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid       = 1'b1;
		request_matrix = req;
		do @(posedge clk); while (!in_ready);
		board.note_request(req);
	endtask

	// Stop sending and wait for every outstanding matching
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	// Result side: random stalls and steady stretches
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(20, 60)) begin
					@(negedge clk);
					out_ready = 1'b1;
				end
			end else begin
				repeat (pick_gap()) begin
					@(negedge clk);
					out_ready = 1'b0;
				end
				repeat ($urandom_range(1, 4)) begin
					@(negedge clk);
					out_ready = 1'b1;
				end
			end
		end
	end

	// Compare each accepted matching
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_grant(grant_valid, grant_inputs);
	end

	// Hard stop
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Stimulus
	initial begin
		logic [rrcm_pkg::REQ_W-1:0] directed[$];
		int                         sent;
		int                         block_len;
		bit                         burst;
		board          = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		request_matrix = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Corner patterns: empty, full with pointer rotation, hot input columns,
		// diagonals, single busy output, pointers cleared back to none
		directed = '{
			64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
			64'hFFFFFFFFFFFFFFFF, 64'h0101010101010101, 64'h8080808080808080,
			64'h8040201008040201, 64'h0102040810204080, 64'hFF00000000000000,
			64'h00000000000000FF, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555,
			64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF, 64'h8000000000000001,
			64'h7F7F7F7F7F7F7F7F, 64'hFEFEFEFEFEFEFEFE, 64'h0303030303030303,
			64'h0303030303030303, 64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF
		};
		foreach (directed[i]) send_matrix(directed[i], (i % 3 == 0) ? pick_gap() : 0);
		wait_drained();

		// Random traffic in blocks, some back to back, one drain midway
		sent = 0;
		while (sent < 880) begin
			block_len = $urandom_range(10, 60);
			burst     = ($urandom_range(0, 3) == 0);
			repeat (block_len) begin
				send_matrix(random_matrix(), burst ? 0 : pick_gap());
				sent++;
			end
			if (sent >= 400 && sent < 400 + block_len) wait_drained();
		end

		wait_drained();
		repeat (4) @(posedge clk);

		$display("Run covered %0d request matrices and %0d matchings.",
			board.requests, board.matchings);
		$display("Outputs granted %0d times and went without a grant %0d times.",
			board.grants, board.idle_outputs);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
